// File: hdl/sha_pkg.sv
// sha_pkg: shared types, constants and functions for the sha-256 stream hasher
// no dependencies; used by every module of the hasher
package sha_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenPos  = 6'd56;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_UPDATE,
    S_PAD1,
    S_PAD2,
    S_OUT_RD,
    S_OUT_CAP,
    S_OUT_HOLD
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD1,
    RET_PAD2,
    RET_OUT
  } ret_t;

  // controls from the sequencer to the round datapath
  typedef struct packed {
    logic load_w;
    logic load_v;
    logic round_en;
    logic shift_v;
  } round_ctl_t;

  function automatic word_t init_h(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = 32'h6a09e667;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t r;
    case (i)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491; 6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5; 6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5; 6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      6'd63: r = 32'hc67178f2;
      default: r = 32'h428a2f98;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/sha_if.sv
// sha_if: valid/ready channel interfaces for input bytes and digest words
// no dependencies
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_message;

  modport source(output valid, data_byte, byte_present, end_message, input ready);
  modport sink(input valid, data_byte, byte_present, end_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: hdl/sha_buf_mem.sv
// sha_buf_mem: 64-byte block buffer, byte write port, 32-bit big-endian word read
// uses sha_pkg
module sha_buf_mem
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       we,
  input  logic [5:0] waddr,
  input  logic [7:0] wdata,
  input  logic [3:0] raddr,
  output word_t      rdata
);

  word_t mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[5:2]][{~waddr[1:0], 3'b000} +: 8] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/sha_hash_mem.sv
// sha_hash_mem: eight 32-bit chaining words, one write and one registered read port
// uses sha_pkg
module sha_hash_mem
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       we,
  input  logic [2:0] waddr,
  input  word_t      wdata,
  input  logic [2:0] raddr,
  output word_t      rdata
);

  word_t mem [8];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/sha_round.sv
// sha_round: working variables a..h, 16-word schedule window and the round logic
// uses sha_pkg
module sha_round
  import sha_pkg::*;
(
  input  logic       clk,
  input  round_ctl_t ctl,
  input  word_t      buf_rdata,
  input  word_t      hash_rdata,
  input  word_t      k,
  output word_t      v0
);

  word_t v [8];
  word_t w [16];

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  word_t s0, s1, w_new, big0, big1, ch, maj, t1, t2;

  always_comb begin
    s0    = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1    = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    big1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1    = v[7] + big1 + ch + k + w[0];
    big0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2    = big0 + maj;
  end

  always_ff @(posedge clk) begin
    // schedule window: w[0] is the word for the current round
    if (ctl.load_w || ctl.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= ctl.load_w ? buf_rdata : w_new;
    end
    if (ctl.round_en) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
    end else if (ctl.load_v || ctl.shift_v) begin
      for (int i = 0; i < 7; i++) begin
        v[i] <= v[i+1];
      end
      v[7] <= hash_rdata;
    end
  end

  assign v0 = v[0];

endmodule

// File: hdl/sha256_stream_hasher.sv
// sha256_stream_hasher: top level, sequencer, padding and digest output
// uses sha_pkg, sha_if, sha_buf_mem, sha_hash_mem and sha_round
//
// Takes one message byte per beat into a 64-byte buffer memory; a byte that
// fills the buffer starts a compression, during which no input is taken.
// A compression loads the schedule window and chaining words from the two
// memories, runs the 64 rounds at one round a cycle, and adds the result back
// into the chaining memory. A beat with end_message pads the block byte by
// byte, runs one or two compressions, then delivers the eight digest words,
// most significant first, each held in an output register until taken, and
// reloads the initial hash values. After reset the same load runs before the
// first beat.
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  sha_in_if.sink        in,
  sha_out_if.source     out
);

  state_t      state, state_next;
  ret_t        ret;
  logic [6:0]  cnt;
  logic [5:0]  fill;
  logic [5:0]  pad_ptr;
  logic [2:0]  idx;
  logic [63:0] byte_total;

  logic        accept;
  logic        buf_we;
  logic [5:0]  buf_waddr;
  logic [7:0]  buf_wdata;
  logic [3:0]  buf_raddr;
  word_t       buf_rdata;
  logic        hash_we;
  logic [2:0]  hash_waddr;
  word_t       hash_wdata;
  logic [2:0]  hash_raddr;
  word_t       hash_rdata;
  round_ctl_t  ctl;
  word_t       v0;

  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;

  assign accept  = in.valid && in.ready;
  assign bit_len = {byte_total[60:0], 3'b000};
  assign len_byte = 8'(bit_len >> {~pad_ptr[2:0], 3'b000});

  always_comb begin
    if (state == S_PAD1 && pad_ptr == fill) begin
      pad_byte = PadByte;
    end else if (pad_ptr >= LenPos && (state == S_PAD2 || fill < LenPos)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (cnt[2:0] == 3'd7) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in.byte_present && fill == 6'd63) state_next = S_LOAD;
          else if (in.end_message) state_next = S_PAD1;
        end
      end
      S_LOAD: begin
        if (cnt == 7'd16) state_next = S_ROUND;
      end
      S_ROUND: begin
        if (cnt == 7'(Rounds - 1)) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (cnt == 7'd8) begin
          case (ret)
            RET_PAD1: state_next = S_PAD1;
            RET_PAD2: state_next = S_PAD2;
            RET_OUT:  state_next = S_OUT_RD;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_PAD1, S_PAD2: begin
        if (pad_ptr == 6'd63) state_next = S_LOAD;
      end
      S_OUT_RD:  state_next = S_OUT_CAP;
      S_OUT_CAP: state_next = S_OUT_HOLD;
      S_OUT_HOLD: begin
        if (out.ready) state_next = (idx == 3'd7) ? S_INIT : S_OUT_RD;
      end
      default: state_next = S_INIT;
    endcase
  end

  // memory and datapath controls
  always_comb begin
    in.ready   = 1'b0;
    buf_we     = 1'b0;
    buf_waddr  = fill;
    buf_wdata  = in.data_byte;
    buf_raddr  = cnt[3:0];
    hash_we    = 1'b0;
    hash_waddr = cnt[2:0];
    hash_wdata = init_h(cnt[2:0]);
    hash_raddr = cnt[2:0];
    ctl        = '0;
    case (state)
      S_INIT: begin
        hash_we = 1'b1;
      end
      S_IDLE: begin
        in.ready = 1'b1;
        buf_we   = in.valid && in.byte_present;
      end
      S_LOAD: begin
        ctl.load_w = cnt != 7'd0;
        ctl.load_v = cnt != 7'd0 && cnt <= 7'd8;
      end
      S_ROUND: begin
        ctl.round_en = 1'b1;
      end
      S_UPDATE: begin
        // each word is written in the cycle after its read
        if (cnt != 7'd0) begin
          hash_we     = 1'b1;
          hash_waddr  = 3'(cnt - 7'd1);
          hash_wdata  = hash_rdata + v0;
          ctl.shift_v = 1'b1;
        end
      end
      S_PAD1, S_PAD2: begin
        buf_we    = 1'b1;
        buf_waddr = pad_ptr;
        buf_wdata = pad_byte;
      end
      S_OUT_RD: begin
        hash_raddr = idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      ret        <= RET_IDLE;
      cnt        <= '0;
      fill       <= '0;
      pad_ptr    <= '0;
      idx        <= '0;
      byte_total <= '0;
      out.valid  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_INIT: begin
          cnt <= (cnt[2:0] == 3'd7) ? 7'd0 : cnt + 7'd1;
        end
        S_IDLE: begin
          if (accept) begin
            if (in.byte_present) begin
              fill       <= fill + 6'd1;
              byte_total <= byte_total + 64'd1;
              pad_ptr    <= fill + 6'd1;
            end else begin
              pad_ptr <= fill;
            end
            ret <= in.end_message ? RET_PAD1 : RET_IDLE;
            cnt <= '0;
          end
        end
        S_LOAD: begin
          cnt <= (cnt == 7'd16) ? 7'd0 : cnt + 7'd1;
        end
        S_ROUND: begin
          cnt <= (cnt == 7'(Rounds - 1)) ? 7'd0 : cnt + 7'd1;
        end
        S_UPDATE: begin
          cnt     <= (cnt == 7'd8) ? 7'd0 : cnt + 7'd1;
          pad_ptr <= '0;
          idx     <= '0;
        end
        S_PAD1: begin
          pad_ptr <= pad_ptr + 6'd1;
          if (pad_ptr == 6'd63) begin
            ret <= (fill < LenPos) ? RET_OUT : RET_PAD2;
          end
        end
        S_PAD2: begin
          pad_ptr <= pad_ptr + 6'd1;
          if (pad_ptr == 6'd63) ret <= RET_OUT;
        end
        S_OUT_CAP: begin
          out.valid <= 1'b1;
        end
        S_OUT_HOLD: begin
          if (out.ready) begin
            out.valid <= 1'b0;
            idx       <= idx + 3'd1;
            if (idx == 3'd7) begin
              fill       <= '0;
              byte_total <= '0;
              cnt        <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // digest payload register
  always_ff @(posedge clk) begin
    if (state == S_OUT_CAP) begin
      out.digest_word <= hash_rdata;
      out.word_index  <= idx;
      out.last_word   <= idx == 3'd7;
    end
  end

  sha_buf_mem u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  sha_hash_mem u_hash (
    .clk   (clk),
    .we    (hash_we),
    .waddr (hash_waddr),
    .wdata (hash_wdata),
    .raddr (hash_raddr),
    .rdata (hash_rdata)
  );

  sha_round u_round (
    .clk        (clk),
    .ctl        (ctl),
    .buf_rdata  (buf_rdata),
    .hash_rdata (hash_rdata),
    .k          (round_k(cnt[5:0])),
    .v0         (v0)
  );

endmodule
